// ----- src/dclp_pkg.sv -----
package dclp_pkg;

	// Default sizes of the display text area, number fields and line queue
	localparam int TEXT_COLS_DEF   = 21;
	localparam int TEXT_ROWS_DEF   = 8;
	localparam int MAX_DIGITS_DEF  = 2;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Parsed numbers saturate at 127 and fit in 7 bits
	localparam int         NUM_W   = 7;
	localparam logic [6:0] NUM_SAT = 7'd127;

	// Characters
	localparam logic [7:0] CH_NL   = 8'd10;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_NUL  = 8'h00;

	// Command codes
	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_HAND = 3'd1;
	localparam logic [2:0] CMD_TEXT = 3'd2;
	localparam logic [2:0] CMD_BL   = 3'd3;
	localparam logic [2:0] CMD_WAIT = 3'd4;
	localparam logic [2:0] CMD_INV  = 3'd5;
	localparam logic [2:0] CMD_CLR  = 3'd6;

	// Reply codes
	localparam logic [1:0] REP_NONE   = 2'd0;
	localparam logic [1:0] REP_ACK    = 2'd1;
	localparam logic [1:0] REP_REFUSE = 2'd2;

	typedef enum logic [3:0] {
		PH_B,
		PH_G,
		PH_N,
		PH_OP,
		PH_INV,
		PH_UND,
		PH_X,
		PH_Y,
		PH_TEXT,
		PH_BL,
		PH_SKIP,
		PH_TEXT_END
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_LOAD,
		BK_CMD
	} bk_state_t;

	// Queue entry: either one text character or the end-of-line summary
	typedef struct packed {
		logic             line_end;
		logic [7:0]       data;
		logic [2:0]       cmd;
		logic [1:0]       rep;
		logic [NUM_W-1:0] pos_x;
		logic [NUM_W-1:0] pos_y;
		logic             inv;
		logic             und;
		logic             bl;
		logic             emit;
	} entry_t;

	typedef struct packed {
		logic             is_command;
		logic [2:0]       command;
		logic [1:0]       reply;
		logic [7:0]       text_char;
		logic [NUM_W-1:0] column;
		logic [NUM_W-1:0] row;
		logic             inverted;
		logic             underline;
		logic             backlight_on;
		logic [NUM_W-1:0] text_length;
		logic             last;
	} result_t;

	function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
		input logic [3:0] d);
		logic [10:0] n;
		n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {7'd0, d};
		return (n > {4'd0, NUM_SAT}) ? NUM_SAT : n[NUM_W-1:0];
	endfunction

	function automatic logic [2:0] opcode_of(input logic [7:0] c);
		logic [2:0] op;
		case (c)
			CH_H:    op = CMD_HAND;
			CH_T:    op = CMD_TEXT;
			CH_B:    op = CMD_BL;
			CH_W:    op = CMD_WAIT;
			CH_I:    op = CMD_INV;
			CH_C:    op = CMD_CLR;
			default: op = CMD_NONE;
		endcase
		return op;
	endfunction

endpackage

// ----- src/dclp_fifo.sv -----
module dclp_fifo #(
	parameter int DEPTH = dclp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dclp_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output dclp_pkg::entry_t rdata,
	output logic            empty
);
	import dclp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

// ----- src/dclp_front.sv -----
module dclp_front #(
	parameter int TEXT_COLS  = dclp_pkg::TEXT_COLS_DEF,
	parameter int TEXT_ROWS  = dclp_pkg::TEXT_ROWS_DEF,
	parameter int MAX_DIGITS = dclp_pkg::MAX_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	input  logic [7:0]       rx_byte,
	input  logic             q_full,
	output logic             accept,
	output logic             push,
	output dclp_pkg::entry_t entry
);
	import dclp_pkg::*;

	localparam int DIG_W = $clog2(MAX_DIGITS + 1);

	phase_t           phase_q, phase_d;
	logic             hs_q, hs_d;
	logic             rej_q, rej_d;
	logic [2:0]       op_q, op_d;
	logic [2:0]       flags_q, flags_d;
	logic [NUM_W-1:0] x_q, x_d, y_q, y_d;
	logic [DIG_W-1:0] xn_q, xn_d, yn_q, yn_d;

	logic       is_digit;
	logic [3:0] digit;
	logic       line_ok;

	assign accept   = rx_valid && !q_full;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit    = 4'(rx_byte - CH_ZERO);
	assign line_ok  = !rej_q && !(phase_q == PH_B || phase_q == PH_G ||
		phase_q == PH_N || phase_q == PH_OP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_B;
			hs_q    <= 1'b0;
			rej_q   <= 1'b0;
			op_q    <= CMD_NONE;
			flags_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
			xn_q    <= '0;
			yn_q    <= '0;
		end else begin
			phase_q <= phase_d;
			hs_q    <= hs_d;
			rej_q   <= rej_d;
			op_q    <= op_d;
			flags_q <= flags_d;
			x_q     <= x_d;
			y_q     <= y_d;
			xn_q    <= xn_d;
			yn_q    <= yn_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hs_d    = hs_q;
		rej_d   = rej_q;
		op_d    = op_q;
		flags_d = flags_q;
		x_d     = x_q;
		y_d     = y_q;
		xn_d    = xn_q;
		yn_d    = yn_q;
		push    = 1'b0;
		entry   = '0;

		if (accept) begin
			if (rx_byte == CH_NL) begin
				push           = 1'b1;
				entry.line_end = 1'b1;
				if (line_ok) begin
					entry.cmd = op_q;
					if (op_q == CMD_HAND) begin
						hs_d      = 1'b1;
						entry.rep = REP_ACK;
					end else if (!hs_q) begin
						entry.rep = REP_REFUSE;
					end else if (op_q == CMD_TEXT) begin
						if (x_q >= NUM_W'(TEXT_COLS) || y_q >= NUM_W'(TEXT_ROWS)) begin
							entry.rep = REP_REFUSE;
						end else begin
							entry.rep   = REP_ACK;
							entry.emit  = 1'b1;
							entry.pos_x = x_q;
							entry.pos_y = y_q;
							entry.inv   = flags_q[0];
							entry.und   = flags_q[1];
						end
					end else begin
						entry.rep = REP_ACK;
						entry.bl  = (op_q == CMD_BL) && flags_q[2];
					end
				end
				// line state back to start; handshake is kept
				phase_d = PH_B;
				rej_d   = 1'b0;
				op_d    = CMD_NONE;
				flags_d = '0;
				x_d     = '0;
				y_d     = '0;
				xn_d    = '0;
				yn_d    = '0;
			end else begin
				unique case (phase_q)
					PH_B: begin
						if (rx_byte == CH_B) phase_d = PH_G;
						else begin rej_d = 1'b1; phase_d = PH_SKIP; end
					end
					PH_G: begin
						if (rx_byte == CH_G) phase_d = PH_N;
						else begin rej_d = 1'b1; phase_d = PH_SKIP; end
					end
					PH_N: begin
						if (rx_byte == CH_N) phase_d = PH_OP;
						else begin rej_d = 1'b1; phase_d = PH_SKIP; end
					end
					PH_OP: begin
						op_d = opcode_of(rx_byte);
						if (op_d == CMD_NONE) begin
							rej_d   = 1'b1;
							phase_d = PH_SKIP;
						end else if (op_d == CMD_TEXT) begin
							phase_d = PH_INV;
						end else if (op_d == CMD_BL) begin
							phase_d = PH_BL;
						end else begin
							phase_d = PH_SKIP;
						end
					end
					PH_INV: begin
						if (rx_byte == CH_ONE) flags_d[0] = 1'b1;
						phase_d = PH_UND;
					end
					PH_UND: begin
						if (rx_byte == CH_ONE) flags_d[1] = 1'b1;
						phase_d = PH_X;
					end
					PH_X: begin
						if (is_digit) begin
							x_d  = add_digit(x_q, digit);
							xn_d = xn_q + 1'b1;
							if (xn_d >= DIG_W'(MAX_DIGITS)) phase_d = PH_Y;
						end else begin
							phase_d = PH_Y;
						end
					end
					PH_Y: begin
						if (is_digit) begin
							y_d  = add_digit(y_q, digit);
							yn_d = yn_q + 1'b1;
							if (yn_d >= DIG_W'(MAX_DIGITS)) phase_d = PH_TEXT;
						end else begin
							phase_d = PH_TEXT;
						end
					end
					PH_TEXT: begin
						if (rx_byte == CH_NUL) begin
							phase_d = PH_TEXT_END;
						end else begin
							// overflow past the last column is dropped in the back end
							push       = 1'b1;
							entry.data = rx_byte;
						end
					end
					PH_BL: begin
						if (rx_byte == CH_ONE) flags_d[2] = 1'b1;
						phase_d = PH_SKIP;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- src/dclp_back.sv -----
module dclp_back #(
	parameter int TEXT_COLS = dclp_pkg::TEXT_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dclp_pkg::entry_t  q_entry,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output dclp_pkg::result_t res
);
	import dclp_pkg::*;

	localparam int CNT_W = $clog2(TEXT_COLS + 1);
	localparam int IDX_W = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1;

	logic [7:0]       text_mem [TEXT_COLS];
	logic [7:0]       rdata_q;
	bk_state_t        state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           line_q;
	logic             out_valid_q;
	result_t          res_q;

	logic slot_free;
	logic wr_en;
	logic load_text, load_cmd, take_line;
	logic [NUM_W-1:0] len_ext;

	assign slot_free = !out_valid_q || !res_stall;
	assign pop       = (state_q == BK_IDLE) && !q_empty;
	assign take_line = pop && q_entry.line_end;
	assign wr_en     = pop && !q_entry.line_end && (cnt_q < CNT_W'(TEXT_COLS));
	assign len_ext   = NUM_W'(cnt_q);
	assign res_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[cnt_q[IDX_W-1:0]] <= q_entry.data;
		end
		rdata_q <= text_mem[idx_q];
	end

	always_comb begin
		state_d   = state_q;
		load_text = 1'b0;
		load_cmd  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (take_line) begin
					state_d = (q_entry.emit && cnt_q != '0) ? BK_FETCH : BK_CMD;
				end
			end
			BK_FETCH: state_d = BK_LOAD;
			BK_LOAD: begin
				if (slot_free) begin
					load_text = 1'b1;
					state_d   = (CNT_W'(idx_q) + 1'b1 == cnt_q) ? BK_CMD : BK_FETCH;
				end
			end
			BK_CMD: begin
				if (slot_free) begin
					load_cmd = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_text) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_cmd) begin
				cnt_q <= '0;
				idx_q <= '0;
			end
			if (load_text || load_cmd) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_line) begin
			line_q <= q_entry;
		end
		if (load_text) begin
			res_q.is_command   <= 1'b0;
			res_q.command      <= CMD_TEXT;
			res_q.reply        <= REP_ACK;
			res_q.text_char    <= rdata_q;
			res_q.column       <= line_q.pos_x;
			res_q.row          <= line_q.pos_y;
			res_q.inverted     <= line_q.inv;
			res_q.underline    <= line_q.und;
			res_q.backlight_on <= 1'b0;
			res_q.text_length  <= len_ext;
			res_q.last         <= 1'b0;
		end else if (load_cmd) begin
			res_q.is_command   <= 1'b1;
			res_q.command      <= line_q.cmd;
			res_q.reply        <= line_q.rep;
			res_q.text_char    <= '0;
			res_q.column       <= line_q.pos_x;
			res_q.row          <= line_q.pos_y;
			res_q.inverted     <= line_q.inv;
			res_q.underline    <= line_q.und;
			res_q.backlight_on <= line_q.bl;
			res_q.text_length  <= line_q.emit ? len_ext : '0;
			res_q.last         <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_LOAD) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("text read index past fill count");
	a_drain_only_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FETCH) |-> (line_q.emit && line_q.cmd == CMD_TEXT))
		else $error("text drained for a line that does not emit text");
`endif

endmodule

// ----- src/display_command_line_parser.sv -----
// Channel   Direction  Handshake            Word
// rx        in         rx_valid / rx_stall  rx_byte
// res       out        res_valid / res_stall is_command, command, reply, text_char,
//                                           column, row, inverted, underline,
//                                           backlight_on, text_length, last
//
// One byte is taken per cycle while the line queue has room; result words come
// out only after a newline.
// After a newline the back end gives each stored text character by a memory read,
// then an output load, and then gives the command word.
// Reset (arst_n low) clears the parser, the handshake flag, the queue and res_valid.
// res_stall holds the output register; the queue then fills and raises rx_stall.
module display_command_line_parser #(
	parameter int TEXT_COLS   = dclp_pkg::TEXT_COLS_DEF,
	parameter int TEXT_ROWS   = dclp_pkg::TEXT_ROWS_DEF,
	parameter int MAX_DIGITS  = dclp_pkg::MAX_DIGITS_DEF,
	parameter int QUEUE_DEPTH = dclp_pkg::QUEUE_DEPTH_DEF,
	localparam int COL_W = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1,
	localparam int ROW_W = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1,
	localparam int LEN_W = $clog2(TEXT_COLS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rx_valid,
	output logic             rx_stall,
	input  logic [7:0]       rx_byte,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             is_command,
	output logic [2:0]       command,
	output logic [1:0]       reply,
	output logic [7:0]       text_char,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic             inverted,
	output logic             underline,
	output logic             backlight_on,
	output logic [LEN_W-1:0] text_length,
	output logic             last
);
	import dclp_pkg::*;

	// front end -> queue
	logic   f_push;
	logic   f_accept;
	entry_t f_entry;
	// queue -> back end
	logic   q_full, q_empty, b_pop;
	entry_t q_entry;
	result_t res;

	assign rx_stall = q_full;

	// parses the byte stream; one queue word per text char or newline
	dclp_front #(
		.TEXT_COLS  (TEXT_COLS),
		.TEXT_ROWS  (TEXT_ROWS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.accept   (f_accept),
		.push     (f_push),
		.entry    (f_entry)
	);

	// short queue lets parsing of the next line overlap the text drain
	dclp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_entry),
		.full   (q_full),
		.pop    (b_pop),
		.rdata  (q_entry),
		.empty  (q_empty)
	);

	// holds the text memory and sequences the result words
	dclp_back #(
		.TEXT_COLS (TEXT_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (q_entry),
		.pop       (b_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign is_command   = res.is_command;
	assign command      = res.command;
	assign reply        = res.reply;
	assign text_char    = res.text_char;
	assign column       = res.column[COL_W-1:0];
	assign row          = res.row[ROW_W-1:0];
	assign inverted     = res.inverted;
	assign underline    = res.underline;
	assign backlight_on = res.backlight_on;
	assign text_length  = res.text_length[LEN_W-1:0];
	assign last         = res.last;

`ifndef SYNTHESIS
	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> f_accept)
		else $error("queue word without an accepted byte");
	a_newline_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(f_accept && rx_byte == CH_NL) |-> (f_push && f_entry.line_end))
		else $error("newline did not queue a line end");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dclp_pkg::*;

	localparam int COLS        = TEXT_COLS_DEF;
	localparam int ROWS        = TEXT_ROWS_DEF;
	localparam int DIGITS      = MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	// One result word at the port widths of the block
	typedef struct packed {
		logic       is_command;
		logic [2:0] command;
		logic [1:0] reply;
		logic [7:0] text_char;
		logic [4:0] column;
		logic [2:0] row;
		logic       inverted;
		logic       underline;
		logic       backlight_on;
		logic [4:0] text_length;
		logic       last;
	} line_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       is_command;
	logic [2:0] command;
	logic [1:0] reply;
	logic [7:0] text_char;
	logic [4:0] column;
	logic [2:0] row;
	logic       inverted;
	logic       underline;
	logic       backlight_on;
	logic [4:0] text_length;
	logic       last;

	display_command_line_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.is_command(is_command),
		.command(command),
		.reply(reply),
		.text_char(text_char),
		.column(column),
		.row(row),
		.inverted(inverted),
		.underline(underline),
		.backlight_on(backlight_on),
		.text_length(text_length),
		.last(last)
	);

	always #6 clk = ~clk;

	line_word_t expected_words[$];
	logic [7:0] line_bytes[$];
	int errors = 0;
	int bytes_sent = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int res_stall_pct = 0;

	// Parser state mirror
	phase_t     prs_phase = PH_B;
	logic       shaken = 1'b0;
	logic       rejected = 1'b0;
	logic [2:0] op_seen = CMD_NONE;
	logic [2:0] flags = 3'd0;
	int         x_val = 0;
	int         x_cnt = 0;
	int         y_val = 0;
	int         y_cnt = 0;
	logic [7:0] text_buf[COLS];
	int         text_cnt = 0;

	function automatic string word_str(input line_word_t w);
		return $sformatf({"cmdw=%0d cmd=%0d rep=%0d chr=%02h col=%0d row=%0d",
			" inv=%0d und=%0d bl=%0d len=%0d last=%0d"},
			w.is_command, w.command, w.reply, w.text_char, w.column, w.row,
			w.inverted, w.underline, w.backlight_on, w.text_length, w.last);
	endfunction

	function automatic int push_digit(input int v, input logic [7:0] c);
		int n;
		n = v * 10 + int'(c - CH_ZERO);
		return (n > int'(NUM_SAT)) ? int'(NUM_SAT) : n;
	endfunction

	function automatic logic [2:0] decode_op(input logic [7:0] c);
		case (c)
			CH_H:    return CMD_HAND;
			CH_T:    return CMD_TEXT;
			CH_B:    return CMD_BL;
			CH_W:    return CMD_WAIT;
			CH_I:    return CMD_INV;
			CH_C:    return CMD_CLR;
			default: return CMD_NONE;
		endcase
	endfunction

	// Advances the parser mirror by one accepted byte; a newline queues the
	// text words and the command word of the line.
	task automatic parse_rx_byte(input logic [7:0] c);
		line_word_t w;
		logic is_digit;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_NL) begin
			w = '0;
			w.is_command = 1'b1;
			w.last = 1'b1;
			if (!rejected && prs_phase > PH_OP) begin
				w.command = op_seen;
				if (op_seen == CMD_HAND) begin
					shaken = 1'b1;
					w.reply = REP_ACK;
				end else if (!shaken) begin
					w.reply = REP_REFUSE;
				end else if (op_seen == CMD_TEXT) begin
					if (x_val >= COLS || y_val >= ROWS) begin
						w.reply = REP_REFUSE;
					end else begin
						w.reply = REP_ACK;
						w.column = 5'(x_val);
						w.row = 3'(y_val);
						w.inverted = flags[0];
						w.underline = flags[1];
						w.text_length = 5'(text_cnt);
						for (int i = 0; i < text_cnt; i++) begin
							line_word_t t;
							t = w;
							t.is_command = 1'b0;
							t.text_char = text_buf[i];
							t.last = 1'b0;
							expected_words.push_back(t);
						end
					end
				end else begin
					w.reply = REP_ACK;
					if (op_seen == CMD_BL)
						w.backlight_on = flags[2];
				end
			end
			expected_words.push_back(w);
			prs_phase = PH_B;
			rejected = 1'b0;
			op_seen = CMD_NONE;
			flags = 3'd0;
			x_val = 0;
			x_cnt = 0;
			y_val = 0;
			y_cnt = 0;
			text_cnt = 0;
		end else begin
			case (prs_phase)
				PH_B, PH_G, PH_N: begin
					if ((prs_phase == PH_B && c == CH_B) || (prs_phase == PH_G && c == CH_G)
							|| (prs_phase == PH_N && c == CH_N)) begin
						prs_phase = (prs_phase == PH_B) ? PH_G : (prs_phase == PH_G) ? PH_N : PH_OP;
					end else begin
						rejected = 1'b1;
						prs_phase = PH_SKIP;
					end
				end
				PH_OP: begin
					op_seen = decode_op(c);
					if (op_seen == CMD_NONE) begin
						rejected = 1'b1;
						prs_phase = PH_SKIP;
					end else if (op_seen == CMD_TEXT) begin
						prs_phase = PH_INV;
					end else if (op_seen == CMD_BL) begin
						prs_phase = PH_BL;
					end else begin
						prs_phase = PH_SKIP;
					end
				end
				PH_INV: begin
					if (c == CH_ONE)
						flags[0] = 1'b1;
					prs_phase = PH_UND;
				end
				PH_UND: begin
					if (c == CH_ONE)
						flags[1] = 1'b1;
					prs_phase = PH_X;
				end
				PH_X: begin
					if (is_digit) begin
						x_val = push_digit(x_val, c);
						x_cnt++;
						if (x_cnt >= DIGITS)
							prs_phase = PH_Y;
					end else begin
						prs_phase = PH_Y;
					end
				end
				PH_Y: begin
					if (is_digit) begin
						y_val = push_digit(y_val, c);
						y_cnt++;
						if (y_cnt >= DIGITS)
							prs_phase = PH_TEXT;
					end else begin
						prs_phase = PH_TEXT;
					end
				end
				PH_TEXT: begin
					if (c == CH_NUL)
						prs_phase = PH_TEXT_END;
					else if (text_cnt < COLS) begin
						text_buf[text_cnt] = c;
						text_cnt++;
					end
				end
				PH_BL: begin
					if (c == CH_ONE)
						flags[2] = 1'b1;
					prs_phase = PH_SKIP;
				end
				default: ;
			endcase
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	// with rx_valid still high, so back-to-back words need no re-raise.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		parse_rx_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line();
		while (line_bytes.size() != 0)
			send_byte(line_bytes.pop_front());
	endtask

	// Holds the sender off until every queued result word has come out
	task automatic wait_drained();
		rx_valid <= 1'b0;
		@(negedge clk);
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] any_but_newline();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == CH_NL)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		b = any_but_newline();
		while (b >= CH_ZERO && b <= CH_NINE)
			b = any_but_newline();
		return b;
	endfunction

	function automatic logic [7:0] printable_char();
		logic [7:0] b;
		b = any_but_newline();
		while (b == CH_NUL)
			b = any_but_newline();
		return b;
	endfunction

	// Mostly in range, sometimes far out; one or two digits, or none at all
	task automatic append_number(input int limit);
		int v;
		int form;
		v = ($urandom_range(99) < 70) ? $urandom_range(limit - 1) : $urandom_range(99);
		form = $urandom_range(9);
		if (form == 0) begin
			line_bytes.push_back(non_digit());
		end else if (v < 10 && form < 5) begin
			line_bytes.push_back(8'(CH_ZERO + v));
			line_bytes.push_back(non_digit());
		end else begin
			line_bytes.push_back(8'(CH_ZERO + v / 10));
			line_bytes.push_back(8'(CH_ZERO + v % 10));
		end
	endtask

	task automatic append_flag();
		line_bytes.push_back($urandom_range(1) ? CH_ONE : any_but_newline());
	endtask

	task automatic build_random_line();
		int kind;
		int n;
		logic [2:0] op;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// noise
			n = $urandom_range(12);
			repeat (n)
				line_bytes.push_back(any_but_newline());
		end else begin
			line_bytes.push_back(CH_B);
			line_bytes.push_back(CH_G);
			line_bytes.push_back(CH_N);
			if (kind < 14)
				line_bytes[$urandom_range(2)] = any_but_newline();
			case ($urandom_range(11))
				0, 1:          op = CMD_HAND;
				2, 3, 4, 5, 6: op = CMD_TEXT;
				7:             op = CMD_BL;
				8:             op = CMD_WAIT;
				9:             op = CMD_INV;
				10:            op = CMD_CLR;
				default:       op = CMD_NONE;
			endcase
			case (op)
				CMD_HAND: line_bytes.push_back(CH_H);
				CMD_TEXT: line_bytes.push_back(CH_T);
				CMD_BL:   line_bytes.push_back(CH_B);
				CMD_WAIT: line_bytes.push_back(CH_W);
				CMD_INV:  line_bytes.push_back(CH_I);
				CMD_CLR:  line_bytes.push_back(CH_C);
				default:  line_bytes.push_back(any_but_newline());
			endcase
			if (op == CMD_TEXT) begin
				append_flag();
				append_flag();
				append_number(COLS);
				append_number(ROWS);
				n = ($urandom_range(9) == 0) ? $urandom_range(22, 30) : $urandom_range(21);
				repeat (n)
					line_bytes.push_back(printable_char());
				if (n > 0 && $urandom_range(9) == 0)
					line_bytes[line_bytes.size() - 1 - $urandom_range(n - 1)] = CH_NUL;
			end else begin
				if (op == CMD_BL)
					append_flag();
				if ($urandom_range(3) == 0) begin
					n = $urandom_range(1, 4);
					repeat (n)
						line_bytes.push_back(any_but_newline());
				end
			end
			// cut the line short now and then
			if ($urandom_range(99) < 12) begin
				n = $urandom_range(line_bytes.size());
				while (line_bytes.size() > n)
					void'(line_bytes.pop_back());
			end
		end
		line_bytes.push_back(CH_NL);
	endtask

	// Everything but the handshake is refused until one has been seen
	task automatic test_before_handshake();
		send_str("BGNT\n");
		send_str("BGNB1\n");
	endtask

	task automatic test_framing_errors();
		send_str("XGNH\n");
		send_str("\n");
		send_str("BGNQ\n");
		send_str("BGN\n");
	endtask

	task automatic test_simple_commands();
		send_str("BGNH!\n");
		send_str("BGNB1z\n");
		send_str("BGNB0\n");
		send_str("BGNW\n");
		send_str("BGNI\n");
		send_str("BGNC\n");
	endtask

	task automatic test_draw_text();
		// last column and row, nul ends text, top bit set in a char
		send_str("BGNT11207,H");
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_str("z\n");
		send_str("BGNT0021\n");
		send_str("BGNT105,8\n");
		send_str("BGNT1199\n");
		send_str("BGNT0012\n");
		send_str("BGNT1\n");
		send_str("BGNT000;0;ABCDEFGHIJKLMNOPQRSTUVWX\n");
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int quota);
		int start;
		send_gap_pct = gap_pct;
		res_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < quota) begin
			build_random_line();
			send_line();
		end
		wait_drained();
	endtask

	always @(negedge clk)
		res_stall <= ($urandom_range(99) < res_stall_pct);

	// Result checker
	always @(posedge clk) begin
		line_word_t got;
		line_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = '{is_command, command, reply, text_char, column, row, inverted,
				underline, backlight_on, text_length, last};
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: %s", word_str(got));
			end else begin
				want = expected_words.pop_front();
				if (got.is_command !== want.is_command || got.command !== want.command
						|| got.reply !== want.reply || got.text_char !== want.text_char
						|| got.column !== want.column || got.row !== want.row
						|| got.inverted !== want.inverted || got.underline !== want.underline
						|| got.backlight_on !== want.backlight_on
						|| got.text_length !== want.text_length || got.last !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %s\n          got      %s",
							word_str(want), word_str(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_before_handshake();
		test_framing_errors();
		test_simple_commands();
		test_draw_text();
		wait_drained();
		test_random_traffic(0, 0, 60);
		test_random_traffic(53, 0, 60);
		test_random_traffic(0, 53, 60);
		test_random_traffic(12, 12, 60);
		repeat (SETTLE)
			@(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/dclp_pkg.sv
src/dclp_fifo.sv
src/dclp_front.sv
src/dclp_back.sv
src/display_command_line_parser.sv
test/testbench.sv
